/* hw/rtl/sdis_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdis_pkg
// shared types and constants of the set dueling insertion selector
// ----------------------------------------------------------------------------
package sdis_pkg;

  // policy selector width
  localparam int unsigned SEL_W = 10;
  localparam logic [SEL_W-1:0] SEL_MID = SEL_W'(1) << (SEL_W - 1);
  localparam logic [SEL_W-1:0] SEL_MAX = {SEL_W{1'b1}};

  // field widths
  localparam int unsigned IDX_W  = 10;
  localparam int unsigned DRAW_W = 7;
  localparam int unsigned SPG_W  = 11;
  localparam int unsigned THR_W  = 7;
  localparam int unsigned ROLE_W = 2;
  localparam int unsigned SELO_W = 10;

  // one quotient bit per step
  localparam int unsigned DIV_STEPS = IDX_W;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

  // set roles
  localparam logic [ROLE_W-1:0] ROLE_FOLLOWER = 2'd0;
  localparam logic [ROLE_W-1:0] ROLE_LRU_LEAD = 2'd1;
  localparam logic [ROLE_W-1:0] ROLE_BIP_LEAD = 2'd2;

  // register map
  localparam int unsigned APB_AW = 3;
  localparam logic [APB_AW-1:0] ADDR_SETS_PER_GROUP    = 3'd0;
  localparam logic [APB_AW-1:0] ADDR_BIMODAL_THRESHOLD = 3'd4;

  localparam logic [SPG_W-1:0] SPG_RESET = 11'd32;
  localparam logic [THR_W-1:0] THR_RESET = 7'd3;

  typedef struct packed {
    logic [IDX_W-1:0]  set_index;
    logic [DRAW_W-1:0] random_draw;
  } in_req_t;

  typedef struct packed {
    logic              insert_at_mru;
    logic [ROLE_W-1:0] set_role;
    logic [SELO_W-1:0] selector_value;
  } out_rsp_t;

  typedef struct packed {
    logic             start;
    logic [IDX_W-1:0] dividend;
    logic [SPG_W-1:0] divisor;
  } div_ctrl_t;

  typedef struct packed {
    logic             done;
    logic [IDX_W-1:0] quotient;
    logic [SPG_W-1:0] remainder;
  } div_res_t;

endpackage

/* hw/rtl/set_dueling_insertion_selector.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// set_dueling_insertion_selector
// picks mru or lru insertion per cache fill by set dueling with a psel counter
// ----------------------------------------------------------------------------
// a request runs through the bit-serial divider and then the evaluate state; the
//   divider is skipped when sets_per_group is zero
// one request is taken at a time: a new request is accepted only after the
//   last one has been evaluated
// a finished result waits in the output register while the next request runs
// reset: psel counter to midpoint, sets_per_group 32, bimodal_threshold 3
// ----------------------------------------------------------------------------
module set_dueling_insertion_selector (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // fill event request
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  sdis_pkg::in_req_t                in_req_i,
  // insertion decision
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output sdis_pkg::out_rsp_t               out_rsp_o,
  // configuration port
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [sdis_pkg::APB_AW-1:0]      paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);

  // sequencer states
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_EVAL = 2'd2;

  logic [1:0]                          state_q, state_d;
  logic [sdis_pkg::SPG_W-1:0]          spg_q;
  logic [sdis_pkg::THR_W-1:0]          thr_q;
  logic [sdis_pkg::SEL_W-1:0]          sel_q, sel_d;
  logic                                bim_q;
  logic                                nodiv_q, nodiv_d;
  logic                                out_valid_q, out_valid_d;
  sdis_pkg::out_rsp_t                  out_q, out_d;
  logic                                in_acc;
  logic                                eval_go;
  logic                                cfg_wr;
  logic [sdis_pkg::ROLE_W-1:0]         role;
  logic                                mru;
  logic [sdis_pkg::SPG_W-1:0]          cons_ext;
  logic [sdis_pkg::SPG_W-1:0]          spg_m1;
  sdis_pkg::div_ctrl_t                 div_ctrl;
  sdis_pkg::div_res_t                  div_res;

  // ---------------------------------------------------------------------------
  // configuration registers, writes land in the access phase
  // ---------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spg_q <= sdis_pkg::SPG_RESET;
      thr_q <= sdis_pkg::THR_RESET;
    end else if (cfg_wr) begin
      if (paddr == sdis_pkg::ADDR_SETS_PER_GROUP) begin
        spg_q <= pwdata[sdis_pkg::SPG_W-1:0];
      end
      if (paddr == sdis_pkg::ADDR_BIMODAL_THRESHOLD) begin
        thr_q <= pwdata[sdis_pkg::THR_W-1:0];
      end
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == sdis_pkg::ADDR_SETS_PER_GROUP) begin
      prdata = 32'(spg_q);
    end else if (paddr == sdis_pkg::ADDR_BIMODAL_THRESHOLD) begin
      prdata = 32'(thr_q);
    end
  end

  // ---------------------------------------------------------------------------
  // request side: one fill event in flight at a time
  // ---------------------------------------------------------------------------
  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;

  // start the divider on accept unless the group size is zero
  assign div_ctrl.start    = in_acc && (spg_q != '0);
  assign div_ctrl.dividend = in_req_i.set_index;
  assign div_ctrl.divisor  = spg_q;

  sdis_divider u_divider (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (div_ctrl),
    .res_o  (div_res)
  );

  // capture the bimodal draw test at accept
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      bim_q <= (in_req_i.random_draw <= thr_q);
    end
  end

  // ---------------------------------------------------------------------------
  // leader classification from quotient (constituency) and remainder (offset)
  // ---------------------------------------------------------------------------
  assign cons_ext = {1'b0, div_res.quotient};
  assign spg_m1   = spg_q - 1'b1;

  always_comb begin
    role = sdis_pkg::ROLE_FOLLOWER;
    if (!nodiv_q) begin
      if (div_res.remainder == cons_ext) begin
        // lru test wins when both hold
        role = sdis_pkg::ROLE_LRU_LEAD;
      end else if ((cons_ext + div_res.remainder) == spg_m1) begin
        role = sdis_pkg::ROLE_BIP_LEAD;
      end
    end
  end

  // insertion position and psel update
  always_comb begin
    sel_d = sel_q;
    mru   = 1'b1;
    case (role)
      sdis_pkg::ROLE_LRU_LEAD: begin
        mru = 1'b1;
        if (sel_q != sdis_pkg::SEL_MAX) begin
          sel_d = sel_q + 1'b1;
        end
      end
      sdis_pkg::ROLE_BIP_LEAD: begin
        mru = bim_q;
        if (sel_q != '0) begin
          sel_d = sel_q - 1'b1;
        end
      end
      default: begin
        // followers go bimodal once psel is above its midpoint
        mru = (sel_q > sdis_pkg::SEL_MID) ? bim_q : 1'b1;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------------
  // evaluate once the output register is free or being drained
  assign eval_go = (state_q == ST_EVAL) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d     = state_q;
    nodiv_d     = nodiv_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (spg_q == '0) begin
            nodiv_d = 1'b1;
            state_d = ST_EVAL;
          end else begin
            nodiv_d = 1'b0;
            state_d = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        if (div_res.done) begin
          state_d = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (eval_go) begin
          out_valid_d          = 1'b1;
          out_d.insert_at_mru  = mru;
          out_d.set_role       = role;
          out_d.selector_value = sdis_pkg::SELO_W'(sel_d);
          state_d              = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      nodiv_q     <= 1'b0;
      out_valid_q <= 1'b0;
      sel_q       <= sdis_pkg::SEL_MID;
    end else begin
      state_q     <= state_d;
      nodiv_q     <= nodiv_d;
      out_valid_q <= out_valid_d;
      if (eval_go) begin
        sel_q <= sel_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  // a request keeps the block busy in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni) in_acc |=> !in_ready_o)
    else $error("accepted request while busy");

  // psel moves only when a result is produced
  assert property (@(posedge clk_i) disable iff (!rst_ni) !eval_go |=> $stable(sel_q))
    else $error("psel changed outside evaluation");

  // divider finishes only while the sequencer waits for it
  assert property (@(posedge clk_i) disable iff (!rst_ni) div_res.done |-> state_q == ST_DIV)
    else $error("divider done outside divide state");

  // an evaluation always leaves a valid result behind
  assert property (@(posedge clk_i) disable iff (!rst_ni) eval_go |=> out_valid_q)
    else $error("evaluation lost its result");

endmodule

/* hw/rtl/sdis_divider.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdis_divider
// restoring divider, one quotient bit per cycle, results held after done
// ----------------------------------------------------------------------------
module sdis_divider (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  sdis_pkg::div_ctrl_t ctrl_i,
  output sdis_pkg::div_res_t  res_o
);

  logic                               busy_q, busy_d;
  logic                               done_q, done_d;
  logic [sdis_pkg::DIV_CNT_W-1:0]     cnt_q, cnt_d;
  logic [sdis_pkg::SPG_W-1:0]         dsr_q, dsr_d;
  logic [sdis_pkg::SPG_W-1:0]         rem_q, rem_d;
  logic [sdis_pkg::IDX_W-1:0]         quo_q, quo_d;
  logic [sdis_pkg::SPG_W:0]           trial;
  logic [sdis_pkg::SPG_W:0]           diff;

  // shift in the next dividend bit and try a subtract
  assign trial = {rem_q, quo_q[sdis_pkg::IDX_W-1]};
  assign diff  = trial - {1'b0, dsr_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dsr_d  = dsr_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    if (ctrl_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      dsr_d  = ctrl_i.divisor;
      rem_d  = '0;
      quo_d  = ctrl_i.dividend;
    end else if (busy_q) begin
      if (!diff[sdis_pkg::SPG_W]) begin
        rem_d = diff[sdis_pkg::SPG_W-1:0];
        quo_d = {quo_q[sdis_pkg::IDX_W-2:0], 1'b1};
      end else begin
        rem_d = trial[sdis_pkg::SPG_W-1:0];
        quo_d = {quo_q[sdis_pkg::IDX_W-2:0], 1'b0};
      end
      if (cnt_q == sdis_pkg::DIV_CNT_W'(sdis_pkg::DIV_STEPS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dsr_q <= dsr_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign res_o.done      = done_q;
  assign res_o.quotient  = quo_q;
  assign res_o.remainder = rem_q;

endmodule

/* test/set_dueling_insertion_selector_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// set_dueling_insertion_selector_checker
// watches the fill and decision channels and the register port, predicts each
// insertion decision and the selector count, and compares field by field
// ----------------------------------------------------------------------------
module set_dueling_insertion_selector_checker
  import sdis_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_ready_o,
  input  in_req_t           in_req_i,
  input  logic              out_valid_o,
  input  logic              out_ready_i,
  input  out_rsp_t          out_rsp_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  input  logic [31:0]       prdata,
  input  logic              pready,
  output int unsigned       mismatch_count_o,
  output int unsigned       pending_o,
  output int unsigned       checked_o,
  output int unsigned       top_holds_o,
  output int unsigned       floor_holds_o
);

  localparam int unsigned MAX_PRINTS = 20;

  // shadow state and registers
  logic [SEL_W-1:0]     duel_count    = SEL_MID;
  logic [SPG_W-1:0]     group_size    = SPG_RESET;
  logic [THR_W-1:0]     mru_threshold = THR_RESET;

  out_rsp_t    decision_q[$];
  out_rsp_t    want_rsp;
  int unsigned mismatches  = 0;
  int unsigned checked     = 0;
  int unsigned top_holds   = 0;
  int unsigned floor_holds = 0;

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= MAX_PRINTS) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  // role of the set, insertion position, and selector update for one fill
  function automatic out_rsp_t predict_insertion(input in_req_t req);
    out_rsp_t    rsp;
    int unsigned cons;
    int unsigned offs;
    logic        bimodal_hit;
    bimodal_hit  = (req.random_draw <= mru_threshold);
    rsp.set_role = ROLE_FOLLOWER;
    if (group_size != 0) begin
      cons = req.set_index / group_size;
      offs = req.set_index % group_size;
      if (offs == cons) rsp.set_role = ROLE_LRU_LEAD;
      else if (cons + offs == group_size - 1) rsp.set_role = ROLE_BIP_LEAD;
    end
    case (rsp.set_role)
      ROLE_LRU_LEAD: begin
        rsp.insert_at_mru = 1'b1;
        if (duel_count != SEL_MAX) duel_count++;
        else top_holds++;
      end
      ROLE_BIP_LEAD: begin
        rsp.insert_at_mru = bimodal_hit;
        if (duel_count != '0) duel_count--;
        else floor_holds++;
      end
      default: begin
        rsp.insert_at_mru = (duel_count > SEL_MID) ? bimodal_hit : 1'b1;
      end
    endcase
    rsp.selector_value = SELO_W'(duel_count);
    return rsp;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      duel_count    = SEL_MID;
      group_size    = SPG_RESET;
      mru_threshold = THR_RESET;
      decision_q.delete();
    end else begin
      // register port
      if (psel && penable && pready) begin
        if (pwrite) begin
          case (paddr)
            ADDR_SETS_PER_GROUP:    group_size    = pwdata[SPG_W-1:0];
            ADDR_BIMODAL_THRESHOLD: mru_threshold = pwdata[THR_W-1:0];
            default: ;
          endcase
        end else begin
          case (paddr)
            ADDR_SETS_PER_GROUP: begin
              if (prdata[SPG_W-1:0] !== group_size)
                report_mismatch($sformatf("sets_per_group read %0d, written %0d",
                                          prdata[SPG_W-1:0], group_size));
            end
            ADDR_BIMODAL_THRESHOLD: begin
              if (prdata[THR_W-1:0] !== mru_threshold)
                report_mismatch($sformatf("bimodal_threshold read %0d, written %0d",
                                          prdata[THR_W-1:0], mru_threshold));
            end
            default: ;
          endcase
        end
      end

      // decisions are matched before new fills are queued
      if (out_valid_o && out_ready_i) begin
        if (decision_q.size() == 0) begin
          report_mismatch($sformatf("decision with no fill outstanding (mru %0d role %0d sel %0d)",
                                    out_rsp_o.insert_at_mru, out_rsp_o.set_role,
                                    out_rsp_o.selector_value));
        end else begin
          want_rsp = decision_q.pop_front();
          checked++;
          if (out_rsp_o.insert_at_mru !== want_rsp.insert_at_mru)
            report_mismatch($sformatf("decision %0d insert_at_mru %0d, want %0d", checked,
                                      out_rsp_o.insert_at_mru, want_rsp.insert_at_mru));
          if (out_rsp_o.set_role !== want_rsp.set_role)
            report_mismatch($sformatf("decision %0d set_role %0d, want %0d", checked,
                                      out_rsp_o.set_role, want_rsp.set_role));
          if (out_rsp_o.selector_value !== want_rsp.selector_value)
            report_mismatch($sformatf("decision %0d selector_value %0d, want %0d", checked,
                                      out_rsp_o.selector_value, want_rsp.selector_value));
        end
      end

      if (in_valid_i && in_ready_o) decision_q.push_back(predict_insertion(in_req_i));
    end

    mismatch_count_o <= mismatches;
    pending_o        <= decision_q.size();
    checked_o        <= checked;
    top_holds_o      <= top_holds;
    floor_holds_o    <= floor_holds;
  end

endmodule

/* test/set_dueling_insertion_selector_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// set_dueling_insertion_selector_test
// drives fill requests in bursts against a stalling decision sink, steps the
// group size and bimodal threshold through their extremes, and gives the
// verdict from the checker's mismatch count
// ----------------------------------------------------------------------------
module set_dueling_insertion_selector_test;
  import sdis_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned SET_MAX     = (1 << IDX_W) - 1;
  localparam int unsigned DRAW_MAX    = (1 << DRAW_W) - 1;
  localparam int unsigned DRAIN_WAIT  = 30;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  // fill request channel
  logic    in_valid_i = 1'b0;
  logic    in_ready_o;
  in_req_t in_req_i   = '0;

  // decision channel
  logic     out_valid_o;
  logic     out_ready_i = 1'b0;
  out_rsp_t out_rsp_o;

  // register port
  logic              psel    = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite  = 1'b0;
  logic [APB_AW-1:0] paddr   = '0;
  logic [31:0]       pwdata  = '0;
  logic [31:0]       prdata;
  logic              pready;

  // from the checker
  int unsigned mismatch_count;
  int unsigned pending;
  int unsigned checked;
  int unsigned top_holds;
  int unsigned floor_holds;

  int unsigned cycle_count  = 0;
  int unsigned burst_left   = 0;
  int unsigned config_count = 0;

  // 4 ns clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  set_dueling_insertion_selector DUT (.*);

  set_dueling_insertion_selector_checker checker_inst (
    .*,
    .mismatch_count_o (mismatch_count),
    .pending_o        (pending),
    .checked_o        (checked),
    .top_holds_o      (top_holds),
    .floor_holds_o    (floor_holds)
  );

  // hard stop in case a request or decision never completes
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d decisions outstanding", cycle_count, pending);
      $display("== FAIL ==");
      $finish;
    end
  end

  // decision sink: a rotating 16-bit ready pattern, reloaded every so often;
  // one choice is all ones so there are long stretches with no stalls, and the
  // pattern is never all zeros so every stall comes to an end
  logic [15:0] ready_pattern = 16'hFFFF;
  int unsigned pattern_left  = 0;

  always @(posedge clk_i) begin
    if (pattern_left == 0) begin
      pattern_left <= $urandom_range(16, 160);
      case ($urandom_range(0, 3))
        0:       ready_pattern <= 16'hFFFF;
        1:       ready_pattern <= 16'($urandom) | 16'h0001;
        2:       ready_pattern <= (16'($urandom) & 16'($urandom)) | 16'h8000;
        default: ready_pattern <= 16'($urandom) | 16'($urandom) | 16'h0100;
      endcase
    end else begin
      ready_pattern <= {ready_pattern[0], ready_pattern[15:1]};
      pattern_left  <= pattern_left - 1;
    end
    out_ready_i <= ready_pattern[0];
  end

  // one fill request; valid stays up within a burst, a gap of random
  // length drops it before the next burst starts
  task automatic send_fill(input int unsigned set_idx, input int unsigned draw);
    if (burst_left == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 20)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                               : $urandom_range(1, 8);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= in_req_t'{set_index: IDX_W'(set_idx), random_draw: DRAW_W'(draw)};
    do @(posedge clk_i); while (!in_ready_o);
    burst_left--;
  endtask

  // setup and access phase, then an idle cycle with psel low so psel never toggles
  // twice in one step between back-to-back transfers
  task automatic reg_access(input logic wr, input logic [APB_AW-1:0] addr,
                            input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // registers change only once every decision has been taken; upper data
  // bits carry noise that the register must drop; each write is read back
  task automatic apply_config(input int unsigned spg, input int unsigned thr);
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    reg_access(1'b1, ADDR_SETS_PER_GROUP, (32'($urandom) << SPG_W) | 32'(spg));
    reg_access(1'b0, ADDR_SETS_PER_GROUP, '0);
    reg_access(1'b1, ADDR_BIMODAL_THRESHOLD, (32'($urandom) << THR_W) | 32'(thr));
    reg_access(1'b0, ADDR_BIMODAL_THRESHOLD, '0);
    config_count++;
  endtask

  // set index biased toward leader sets of the current group size;
  // lru leaders sit at c*(spg+1), bip leaders at c*spg + spg-1-c
  function automatic int unsigned pick_set(input int unsigned spg, input int unsigned lru_pct,
                                           input int unsigned bip_pct);
    int unsigned roll;
    int unsigned top_c;
    int unsigned c;
    roll = $urandom_range(0, 99);
    if (spg != 0 && roll < lru_pct) begin
      top_c = spg - 1;
      if (top_c > SET_MAX / (spg + 1)) top_c = SET_MAX / (spg + 1);
      c = $urandom_range(0, top_c);
      return c * (spg + 1);
    end
    if (spg != 0 && spg - 1 <= SET_MAX && roll < lru_pct + bip_pct) begin
      if (spg == 1) begin
        top_c = 0;
      end else begin
        top_c = SET_MAX / (spg - 1) - 1;
        if (top_c > spg - 1) top_c = spg - 1;
      end
      c = $urandom_range(0, top_c);
      return c * spg + spg - 1 - c;
    end
    return $urandom_range(0, SET_MAX);
  endfunction

  // mostly the nominal 1..100 range, sometimes anything the field holds
  function automatic int unsigned pick_draw();
    if ($urandom_range(0, 6) == 0) return $urandom_range(0, DRAW_MAX);
    return $urandom_range(1, 100);
  endfunction

  task automatic run_phase(input int unsigned spg, input int unsigned thr,
                           input int unsigned items, input int unsigned lru_pct,
                           input int unsigned bip_pct);
    int unsigned n;
    apply_config(spg, thr);
    for (n = 0; n < items; n++) send_fill(pick_set(spg, lru_pct, bip_pct), pick_draw());
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset registers (group of 32, threshold 3): leaders of both kinds,
    // followers above and at the midpoint, draws at the field extremes
    send_fill(0, 50);           // lru leader, first constituency
    send_fill(31, 3);           // bip leader, draw equal to threshold
    send_fill(62, 4);           // bip leader, draw just above threshold
    send_fill(33, 100);         // lru leader
    send_fill(SET_MAX, DRAW_MAX); // last set is an lru leader
    send_fill(5, 1);            // follower while selector is above midpoint
    send_fill(6, 100);
    send_fill(992, 0);          // bip leader, zero draw
    send_fill(7, 100);          // follower with selector back at midpoint
    send_fill(341, 85);
    send_fill(682, 42);

    // zero group size: no leaders at all, selector untouched
    apply_config(0, 100);
    send_fill(0, 0);
    send_fill(SET_MAX, DRAW_MAX);
    send_fill(31, 1);

    // group of 3: set 4 passes both leader tests and must count as lru;
    // threshold 0 with a zero draw still goes to mru
    apply_config(3, 0);
    send_fill(4, 0);
    send_fill(2, 0);
    send_fill(2, 1);
    send_fill(0, DRAW_MAX);

    // drive the selector down to zero and hold it there
    run_phase(2, 50, 540, 0, 98);
    // then all the way up to saturation, followers now bimodal
    run_phase(1, 0, 1070, 98, 0);
    // no leaders, selector at its top, every draw inside threshold
    run_phase(0, DRAW_MAX, 20, 0, 0);
    // widest group: only set 0 leads
    run_phase((1 << SPG_W) - 1, 100, 20, 30, 30);
    run_phase(1024, $urandom_range(0, 100), 20, 20, 20);
    run_phase($urandom_range(3, 64), $urandom_range(0, 100), 40, 25, 25);

    // drain, then watch a little longer for stray decisions
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    $display("%0d fill decisions checked over %0d register settings plus reset values",
             checked, config_count);
    $display("selector held at its top %0d times and at zero %0d times",
             top_holds, floor_holds);
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
